@@ src/lmb_pkg.sv @@
// Shared constants and types of the learning MAC bridge.
// No dependencies; used by lmb_cell and learning_mac_bridge.
`default_nettype none

package lmb_pkg;

   localparam int MAC_W          = 48;
   localparam int PORT_W         = 3;
   localparam int MASK_W         = 8;
   localparam int ACT_W          = 4;
   localparam int NUM_PORTS      = 8;
   localparam int TABLE_ENTRIES  = 64;
   localparam logic [ACT_W-1:0] ACTIVE_RESET = 4'd8;

   // Probe beat that walks the cell row, gathering lookup results.
   typedef struct packed {
      logic              live;
      logic              src_hit;
      logic              dst_hit;
      logic [PORT_W-1:0] dst_port;
   } probe_type;

endpackage

`default_nettype wire

@@ src/lmb_cell.sv @@
// One table cell of the learning MAC bridge: a stored MAC and port plus
// one stage of the probe row. Depends on lmb_pkg.
`default_nettype none

module lmb_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [lmb_pkg::MAC_W-1:0]     wr_mac,
   input  logic [lmb_pkg::PORT_W-1:0]    wr_port,
   input  logic                          entry_valid,
   input  logic [lmb_pkg::MAC_W-1:0]     key_src,
   input  logic [lmb_pkg::MAC_W-1:0]     key_dst,
   input  lmb_pkg::probe_type            up_probe,
   output lmb_pkg::probe_type            dn_probe
);

   logic [lmb_pkg::MAC_W-1:0]  mac_ff;
   logic [lmb_pkg::PORT_W-1:0] port_ff;
   lmb_pkg::probe_type         probe_ff;
   lmb_pkg::probe_type         probe_in;

   // Merge this entry's match into the passing probe.
   always_comb begin
      probe_in = up_probe;
      if (entry_valid && (mac_ff == key_src)) begin
         probe_in.src_hit = 1'b1;
      end
      if (entry_valid && (mac_ff == key_dst)) begin
         probe_in.dst_hit  = 1'b1;
         probe_in.dst_port = port_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= '0;
      end else begin
         probe_ff <= probe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mac_ff  <= wr_mac;
         port_ff <= wr_port;
      end
   end

   assign dn_probe = probe_ff;

endmodule

`default_nettype wire

@@ src/learning_mac_bridge.sv @@
// Learning MAC bridge: table of learned source MACs held in a row of cells.
// The accepted request launches a probe beat that walks the cell row one cell
// per cycle; rsp_valid is registered from the probe leaving the last cell.
// A new frame is accepted only when idle: busy stays high from accept until
// the probe leaves the last cell.
// Reset (synchronous): table empty, active_ports = 8, no result pending.
// The receiver cannot stall: each result shows for exactly one cycle.
`default_nettype none

module learning_mac_bridge #(
   parameter int TABLE_ENTRIES = lmb_pkg::TABLE_ENTRIES
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          start,
   output logic                          busy,
   input  logic [lmb_pkg::PORT_W-1:0]    req_ingress_port,
   input  logic [lmb_pkg::MAC_W-1:0]     req_src_mac,
   input  logic [lmb_pkg::MAC_W-1:0]     req_dst_mac,
   // response channel
   output logic                          rsp_valid,
   output logic [lmb_pkg::MASK_W-1:0]    rsp_egress_mask,
   output logic                          rsp_flooded,
   output logic                          rsp_learned,
   output logic                          rsp_learn_dropped,
   // configuration
   input  logic                          csr_we,
   input  logic [lmb_pkg::ACT_W-1:0]     csr_wdata
);

   localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   // Flood set: active ports below the configured count, minus the ingress.
   function automatic logic [lmb_pkg::MASK_W-1:0] flood_mask(
      input logic [lmb_pkg::ACT_W-1:0]  act,
      input logic [lmb_pkg::PORT_W-1:0] ing
   );
      logic [lmb_pkg::MASK_W-1:0] m;
      m = '0;
      for (int j = 0; j < lmb_pkg::MASK_W; j++) begin
         if ((j < int'(act)) && (j < lmb_pkg::NUM_PORTS) && (j != int'(ing))) begin
            m[j] = 1'b1;
         end
      end
      return m;
   endfunction

   logic                          state_ff, state_in;
   logic [lmb_pkg::ACT_W-1:0]     active_ff;
   logic [FILL_W-1:0]             fill_ff, fill_in;
   logic                          launch_ff;
   logic [lmb_pkg::MAC_W-1:0]     src_ff;
   logic [lmb_pkg::MAC_W-1:0]     dst_ff;
   logic [lmb_pkg::PORT_W-1:0]    ingress_ff;
   logic                          same_ff;

   logic                          rsp_valid_ff;
   logic [lmb_pkg::MASK_W-1:0]    mask_ff, mask_in;
   logic                          flooded_ff, flooded_in;
   logic                          learned_ff, learned_in;
   logic                          dropped_ff, dropped_in;

   logic                          accept;
   logic                          room;
   logic                          learn_go;
   lmb_pkg::probe_type            tail;

   lmb_pkg::probe_type            chain [0:TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0]      cell_we;
   logic [TABLE_ENTRIES-1:0]      cell_valid;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // Head of the row: one live probe beat the cycle after accept.
   always_comb begin
      chain[0]      = '0;
      chain[0].live = launch_ff;
   end

   assign tail = chain[TABLE_ENTRIES];

   // Slots fill in order, so a slot holds a live entry iff it is below fill.
   // Write a new source into the next free slot, if any, when the probe returns.
   assign room     = (fill_ff < FILL_W'(TABLE_ENTRIES));
   assign learn_go = tail.live && !tail.src_hit && room;

   genvar k;
   generate
      for (k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
         assign cell_valid[k] = (FILL_W'(k) < fill_ff);
         assign cell_we[k]    = learn_go && (fill_ff == FILL_W'(k));

         lmb_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .wr_en       (cell_we[k]),
            .wr_mac      (src_ff),
            .wr_port     (ingress_ff),
            .entry_valid (cell_valid[k]),
            .key_src     (src_ff),
            .key_dst     (dst_ff),
            .up_probe    (chain[k]),
            .dn_probe    (chain[k+1])
         );
      end
   endgenerate

   // Sequencer: hold busy from accept until the probe leaves the last cell.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (tail.live) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign fill_in = learn_go ? (fill_ff + FILL_W'(1)) : fill_ff;

   // Build the result. Learning comes before lookup: a frame whose source
   // equals its destination hits the entry it just created.
   always_comb begin
      learned_in = !tail.src_hit && room;
      dropped_in = !tail.src_hit && !room;
      flooded_in = 1'b0;
      if (tail.dst_hit) begin
         mask_in = lmb_pkg::MASK_W'(1) << tail.dst_port;
      end else if (learned_in && same_ff) begin
         mask_in = lmb_pkg::MASK_W'(1) << ingress_ff;
      end else begin
         mask_in    = flood_mask(active_ff, ingress_ff);
         flooded_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= lmb_pkg::ACTIVE_RESET;
         fill_ff      <= '0;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         launch_ff    <= accept;
         rsp_valid_ff <= tail.live;
         if (csr_we) begin
            active_ff <= csr_wdata;
         end
      end
   end

   // Capture the request beat; the keys stay put while the probe walks.
   always_ff @(posedge clock) begin
      if (accept) begin
         src_ff     <= req_src_mac;
         dst_ff     <= req_dst_mac;
         ingress_ff <= req_ingress_port;
         same_ff    <= (req_src_mac == req_dst_mac);
      end
   end

   always_ff @(posedge clock) begin
      if (tail.live) begin
         mask_ff    <= mask_in;
         flooded_ff <= flooded_in;
         learned_ff <= learned_in;
         dropped_ff <= dropped_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_egress_mask   = mask_ff;
   assign rsp_flooded       = flooded_ff;
   assign rsp_learned       = learned_ff;
   assign rsp_learn_dropped = dropped_ff;

`ifndef ASSERT_OFF
   a_rsp_follows_probe : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(tail.live))
      else $error("response beat without a returning probe");

   a_probe_only_busy : assert property (@(posedge clock) disable iff (reset)
      tail.live |-> (state_ff == ST_RUN))
      else $error("probe returned while idle");

   a_learn_flags : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_learned && rsp_learn_dropped))
      else $error("learned and dropped in one beat");

   a_hit_onehot : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_flooded) |-> $onehot(rsp_egress_mask))
      else $error("forwarded beat without a single egress port");

   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(TABLE_ENTRIES))
      else $error("fill count beyond table size");

   a_fill_step : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_learned) |-> (fill_ff == $past(fill_ff) + FILL_W'(1)))
      else $error("learn did not advance the fill count");
`endif

endmodule

`default_nettype wire
